// ===== rtl/ftl_pkg.sv =====
// ----------------------------------------------------------------------------
// ftl_pkg
// Shared types and constants of the fixed-step tick limiter.
// ----------------------------------------------------------------------------
package ftl_pkg;

    localparam int ELAPSED_W = 32;
    localparam int SCALE_W   = 16;
    localparam int TICKS_W   = 16;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = ELAPSED_W + SCALE_W;
    localparam int SCALE_FRAC_W = 8;
    localparam int STEP_W    = 32;
    localparam int MAX_W     = 16;
    localparam int DIV_STEPS = ACC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0] STEP_SIZE_RESET    = 32'd1092;
    localparam logic [MAX_W-1:0]  MAX_CATCH_UP_RESET = 16'd8;

    localparam logic REG_STEP_SIZE    = 1'b0;
    localparam logic REG_MAX_CATCH_UP = 1'b1;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_PAUSE   = 2'd1,
        OP_RUN     = 2'd2,
        OP_STEP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/fixed_step_tick_limiter.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_limiter
// Fixed-timestep accumulator with a catch-up limit and a single-step request.
// ----------------------------------------------------------------------------
// Each transaction on the input stream produces exactly one output
// transaction. Items are handled one at a time: pause, run and step-request
// items skip the multiply, add and divide phases, while an advance item that
// is running with a nonzero scale passes through all of them, including the
// restoring divider that finds the whole steps in the 40-bit accumulator.
// A finished result waits in the output register, and the next item is taken
// while it waits. Configuration writes are always accepted and must only be
// issued while the block is idle.
module fixed_step_tick_limiter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // elapsed[31:0], scale[47:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // ticks[15:0], paused[16], accumulated[56:17]
);
    import ftl_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [TICKS_W-1:0] ticks;
    logic               paused;
    logic [ACC_W-1:0]   accumulated;

    assign cfg_ready = 1'b1;

    ftl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_op           (op_t'(s_axis_tuser)),
        .in_elapsed      (s_axis_tdata[31:0]),
        .in_scale        (s_axis_tdata[47:32]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_ticks       (ticks),
        .out_paused      (paused),
        .out_accumulated (accumulated)
    );

    assign m_axis_tdata = {7'd0, accumulated, paused, ticks};

    // A paused block always holds an empty accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && paused |-> accumulated == '0)
        else $error("paused result with nonzero accumulator");

    // Only one item is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

endmodule

// ===== rtl/ftl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftl_ctrl
// Sequencer: accepts one item, steps the multiply, add and divide phases if
// it needs a division, and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module ftl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ftl_pkg::sts_t sts,
    output ftl_pkg::cmd_t cmd
);
    import ftl_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.needs_div)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_ADD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ftl_dp.sv =====
// ----------------------------------------------------------------------------
// ftl_dp
// Datapath: configuration and mode registers, scale multiplier, saturating
// accumulator, restoring divider and the output register.
// ----------------------------------------------------------------------------
module ftl_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ftl_pkg::cmd_t                cmd,
    output ftl_pkg::sts_t                sts,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [31:0]                  cfg_data,
    input  ftl_pkg::op_t                 in_op,
    input  logic [ftl_pkg::ELAPSED_W-1:0] in_elapsed,
    input  logic [ftl_pkg::SCALE_W-1:0]  in_scale,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ftl_pkg::TICKS_W-1:0]  out_ticks,
    output logic                         out_paused,
    output logic [ftl_pkg::ACC_W-1:0]    out_accumulated
);
    import ftl_pkg::*;

    logic [STEP_W-1:0]    step_reg;
    logic [MAX_W-1:0]     max_reg;
    logic                 run_reg, run_next;
    logic                 pend_reg, pend_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 out_valid_reg;

    op_t                  op_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [STEP_W-1:0]    rem_reg;
    logic [TICKS_W-1:0]   ticks_reg, ticks_next;
    logic                 paused_reg;
    logic [ACC_W-1:0]     acc_out_reg;

    logic [STEP_W-1:0]    step_eff;
    logic [ACC_W:0]       sum;
    logic [ACC_W-1:0]     sum_sat;
    logic [STEP_W:0]      trial;
    logic                 fits;
    logic [MAX_W-1:0]     req;
    logic [MAX_W-1:0]     cap;
    logic                 over_cap;

    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign sum      = {1'b0, acc_reg} + {1'b0, prod_reg[PROD_W-1:SCALE_FRAC_W]};
    assign sum_sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    assign trial    = {rem_reg, quo_reg[ACC_W-1]};
    assign fits     = trial >= {1'b0, step_eff};

    assign req      = MAX_W'(pend_reg);
    assign cap      = (req >= max_reg) ? '0 : (max_reg - req);
    assign over_cap = quo_reg > ACC_W'(cap);

    assign sts.needs_div = (op_reg == OP_ADVANCE) && run_reg && (scale_reg != '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        run_next   = run_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        ticks_next = '0;
        unique case (op_reg)
            OP_ADVANCE:
            begin
                pend_next  = 1'b0;
                ticks_next = req;
                if (sts.needs_div)
                begin
                    if (over_cap)
                    begin
                        acc_next   = '0;
                        ticks_next = req + cap;
                    end
                    else
                    begin
                        acc_next   = ACC_W'(rem_reg);
                        ticks_next = req + quo_reg[TICKS_W-1:0];
                    end
                end
            end
            OP_PAUSE:
            begin
                run_next = 1'b0;
                acc_next = '0;
            end
            OP_RUN:
            begin
                run_next = 1'b1;
            end
            OP_STEP:
            begin
                pend_next = 1'b1;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_SIZE_RESET;
            max_reg       <= MAX_CATCH_UP_RESET;
            run_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_SIZE:    step_reg <= cfg_data[STEP_W-1:0];
                    REG_MAX_CATCH_UP: max_reg  <= cfg_data[MAX_W-1:0];
                    default:          step_reg <= step_reg;
                endcase
            end
            if (cmd.commit)
            begin
                run_reg       <= run_next;
                pend_reg      <= pend_next;
                acc_reg       <= acc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            elapsed_reg <= in_elapsed;
            scale_reg   <= in_scale;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(elapsed_reg) * PROD_W'(scale_reg);
        end
        if (cmd.add)
        begin
            quo_reg <= sum_sat;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? STEP_W'(trial - {1'b0, step_eff}) : trial[STEP_W-1:0];
        end
        if (cmd.commit)
        begin
            ticks_reg   <= ticks_next;
            paused_reg  <= !run_next;
            acc_out_reg <= acc_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_ticks       = ticks_reg;
    assign out_paused      = paused_reg;
    assign out_accumulated = acc_out_reg;

endmodule

// ===== verif/tb_fixed_step_tick_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_step_tick_limiter
// Self-checking testbench of the fixed-step tick limiter.
// ----------------------------------------------------------------------------
// A short table of directed transactions walks through paused and running
// advances, zero scale, pending single steps, catch-up clamping, zero step
// size, a zero catch-up limit and accumulator saturation. Many rows carry
// their expected result. A long random run under several register settings
// follows. Every output transaction is compared field by field with an
// in-order prediction. Both streams idle at random, and the output side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_fixed_step_tick_limiter;

    timeunit 1ns;
    timeprecision 1ps;

    import ftl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_CYCLES = 300;
    localparam longint unsigned ACC_LIMIT = (64'd1 << ACC_W) - 1;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic               paused;
        logic [ACC_W-1:0]   accumulated;
    } grant_t;

    typedef struct packed {
        logic                 is_cfg;
        logic                 cfg_idx;
        logic [31:0]          cfg_val;
        op_t                  op;
        logic [ELAPSED_W-1:0] elapsed;
        logic [SCALE_W-1:0]   scale;
        logic                 typed;
        grant_t               grant;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_STEP_SIZE;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_ADVANCE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    logic [STEP_W-1:0] step_size;
    logic [MAX_W-1:0]  max_catch_up;
    logic              running;
    logic              step_pending;
    logic [ACC_W-1:0]  time_acc;

    grant_t    expected_grants[$];
    plan_row_t plan[$];

    int in_idle_pct = 30;
    int out_idle_pct = 30;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int clamp_count = 0;
    int sat_count = 0;
    int op_count[4] = '{0, 0, 0, 0};

    fixed_step_tick_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic grant_ticks(input op_t op, input logic [ELAPSED_W-1:0] elapsed,
                               input logic [SCALE_W-1:0] scale, output grant_t res);
        logic [TICKS_W-1:0] granted;
        logic [PROD_W-1:0]  prod;
        logic               req;
        longint unsigned    sum;
        longint unsigned    step_len;
        longint unsigned    avail;
        longint unsigned    cap;
        longint unsigned    cont;
        granted = '0;
        case (op)
            OP_ADVANCE:
            begin
                req = step_pending;
                step_pending = 1'b0;
                granted = {{(TICKS_W-1){1'b0}}, req};
                if (running && scale != 0)
                begin
                    prod = PROD_W'(elapsed) * PROD_W'(scale);
                    sum = 64'(time_acc) + 64'(prod >> SCALE_FRAC_W);
                    if (sum > ACC_LIMIT)
                    begin
                        sum = ACC_LIMIT;
                        sat_count++;
                    end
                    step_len = (step_size == 0) ? 64'd1 : 64'(step_size);
                    avail = sum / step_len;
                    if (avail != 0)
                    begin
                        cap = (64'(req) >= 64'(max_catch_up)) ? 64'd0 :
                              64'(max_catch_up) - 64'(req);
                        cont = (avail > cap) ? cap : avail;
                        if (avail > cont)
                        begin
                            sum = 0;
                            clamp_count++;
                        end
                        else
                            sum = sum - cont * step_len;
                        granted = TICKS_W'(64'(req) + cont);
                    end
                    time_acc = sum[ACC_W-1:0];
                end
            end
            OP_PAUSE:
            begin
                running = 1'b0;
                time_acc = '0;
            end
            OP_RUN:
                running = 1'b1;
            default:
                step_pending = 1'b1;
        endcase
        res = '{granted, ~running, time_acc};
    endtask

    task automatic send_item(input op_t op, input logic [ELAPSED_W-1:0] elapsed,
                             input logic [SCALE_W-1:0] scale, input logic typed,
                             input grant_t typed_grant);
        grant_t predicted;
        if ($urandom_range(99) < in_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {scale, elapsed};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        grant_ticks(op, elapsed, scale, predicted);
        expected_grants.push_back(typed ? typed_grant : predicted);
        op_count[op]++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_grants.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_STEP_SIZE)
            step_size = value[STEP_W-1:0];
        else
            max_catch_up = value[MAX_W-1:0];
        cfg_writes++;
    endtask

    task automatic check_grant(input logic [63:0] data);
        grant_t got;
        grant_t want;
        got = '{data[15:0], data[16], data[56:17]};
        results_checked++;
        if (expected_grants.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: ticks %0d paused %0d acc %0h",
                         got.ticks, got.paused, got.accumulated);
        end
        else
        begin
            want = expected_grants.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: exp ticks %0d paused %0d acc %0h, ",
                              "got ticks %0d paused %0d acc %0h"},
                             results_checked, want.ticks, want.paused,
                             want.accumulated, got.ticks, got.paused,
                             got.accumulated);
            end
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_grant(m_axis_tdata);
            if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        longint unsigned bound;
        int r;
        r = $urandom_range(0, 9);
        bound = ((step_size == 0) ? 64'd1 : 64'(step_size)) * 64'd3;
        if (bound > 64'hFFFF_FFFF)
            bound = 64'hFFFF_FFFF;
        case (r)
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, bound[31:0]);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return 16'hFFFF;
        else if (r < 10)
            return 16'h0100;
        else if (r < 15)
            return SCALE_W'($urandom_range(16'h0040, 16'h0400));
        else
            return SCALE_W'($urandom);
    endfunction

    function automatic op_t pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return OP_ADVANCE;
        else if (r < 75)
            return OP_STEP;
        else if (r < 92)
            return OP_RUN;
        else
            return OP_PAUSE;
    endfunction

    initial
    begin
        logic [31:0] new_step;
        logic [31:0] new_max;
        step_size = STEP_SIZE_RESET;
        max_catch_up = MAX_CATCH_UP_RESET;
        running = 1'b0;
        step_pending = 1'b0;
        time_acc = '0;

        plan = '{
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'h0001_0000, 16'h0100,
              1'b1, '{16'd0, 1'b1, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_STEP, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b1, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'h0001_0000, 16'h0100,
              1'b1, '{16'd1, 1'b1, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'h0001_0000, 16'h0100,
              1'b1, '{16'd0, 1'b1, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_RUN, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'h0000,
              1'b1, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF,
              1'b1, '{16'd8, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd1092, 16'h0100,
              1'b1, '{16'd1, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd1000, 16'h0100,
              1'b1, '{16'd0, 1'b0, 40'd1000}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_STEP, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b0, 40'd1000}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd0, 16'h0001,
              1'b1, '{16'd1, 1'b0, 40'd1000}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_PAUSE, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b1, 40'd0}},
            '{1'b1, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd0, 16'd0,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b1, REG_MAX_CATCH_UP, 32'd0, OP_ADVANCE, 32'd0, 16'd0,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_RUN, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_STEP, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd5, 16'h0100,
              1'b1, '{16'd1, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b1, REG_STEP_SIZE, 32'hFFFF_FFFF, OP_ADVANCE, 32'd0, 16'd0,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b1, REG_MAX_CATCH_UP, 32'h0000_FFFF, OP_ADVANCE, 32'd0, 16'd0,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'd1, 16'h0001,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_STEP, 32'd0, 16'd0,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_ADVANCE, 32'h8000_0000, 16'h8000,
              1'b0, '{16'd0, 1'b0, 40'd0}},
            '{1'b0, REG_STEP_SIZE, 32'd0, OP_PAUSE, 32'd0, 16'd0,
              1'b1, '{16'd0, 1'b1, 40'd0}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cfg_idx, plan[i].cfg_val);
            else
                send_item(plan[i].op, plan[i].elapsed, plan[i].scale,
                          plan[i].typed, plan[i].grant);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    new_step = 32'd1;
                    new_max = 32'd1;
                end
                1:
                begin
                    new_step = 32'hFFFF_FFFF;
                    new_max = 32'h0000_FFFF;
                end
                2:
                begin
                    new_step = 32'd0;
                    new_max = $urandom_range(0, 3);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: new_step = $urandom_range(1, 4096);
                        1: new_step = $urandom_range(4096, 32'h0010_0000);
                        2: new_step = $urandom;
                        default: new_step = STEP_SIZE_RESET;
                    endcase
                    if ($urandom_range(0, 4) == 0)
                        new_max = $urandom_range(0, 16'hFFFF);
                    else
                        new_max = $urandom_range(0, 16);
                end
            endcase
            write_reg(REG_STEP_SIZE, new_step);
            write_reg(REG_MAX_CATCH_UP, new_max);
            in_idle_pct = (phase == 4) ? 0 : 30;
            out_idle_pct = (phase == 4) ? 0 : 30;
            send_item(OP_RUN, '0, '0, 1'b0, '0);
            for (int n = 1; n < PHASE_ITEMS; n++)
                send_item(pick_op(), pick_elapsed(), pick_scale(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("items: %0d advance, %0d pause, %0d run, %0d step; %0d register writes",
                 op_count[OP_ADVANCE], op_count[OP_PAUSE], op_count[OP_RUN],
                 op_count[OP_STEP], cfg_writes);
        $display({"results checked: %0d, clamped advances: %0d, ",
                  "saturations: %0d, mismatches: %0d"},
                 results_checked, clamp_count, sat_count, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ftl_pkg.sv
rtl/ftl_ctrl.sv
rtl/ftl_dp.sv
rtl/fixed_step_tick_limiter.sv
verif/tb_fixed_step_tick_limiter.sv
